@@ hw/rtl/ple_pkg.sv @@
// Shared types and constants of the positional list engine.
// Used by ple_ctrl, ple_dp and positional_list_engine; depends on nothing.
package ple_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned OpW  = 3;
  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 7;
  localparam int unsigned StW  = 3;
  localparam int unsigned InDataW  = 40;  // value + position, padded to bytes
  localparam int unsigned OutDataW = 32;

  typedef enum logic [OpW-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ      = 3'd6
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_RANGE   = 3'd2,
    ST_UNDER   = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read_step;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic read_go;
    logic read_last;
  } sts_t;

endpackage

@@ hw/rtl/ple_ctrl.sv @@
// Controller state machine of the positional list engine.
// Depends on ple_pkg; drives the ple_dp command struct.
module ple_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ple_pkg::sts_t sts_i,
  output ple_pkg::cmd_t cmd_o
);
  import ple_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.slot_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.read_go ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        if (sts_i.slot_free) begin
          cmd_o.read_step = 1'b1;
          if (sts_i.read_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted beat did not enter execute");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE))
    else $error("ready outside idle");

  a_read_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.read_step && sts_i.read_last) |=> (state_q == S_IDLE))
    else $error("read out did not end on last element");

endmodule

@@ hw/rtl/ple_dp.sv @@
// Datapath of the positional list engine: command register, shifting
// cell row, element count, read-out counter and output register. Uses ple_pkg.
module ple_dp #(
  parameter int unsigned CAPACITY = ple_pkg::CapacityDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ple_pkg::cmd_t               cmd_i,
  output ple_pkg::sts_t               sts_o,
  input  logic [ple_pkg::OpW-1:0]     op_i,
  input  logic signed [ple_pkg::ValW-1:0] value_i,
  input  logic [ple_pkg::PosW-1:0]    position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ple_pkg::StW-1:0]     out_status_o,
  output logic signed [ple_pkg::ValW-1:0] out_element_o,
  output logic                        out_last_o
);
  import ple_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  logic [OpW-1:0]         op_q;
  logic signed [ValW-1:0] val_q;
  logic [PosW-1:0]        pos_q;

  logic signed [ValW-1:0] cell_q [CAPACITY];
  logic signed [ValW-1:0] cell_d [CAPACITY];
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        rd_q, rd_d;

  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic signed [ValW-1:0] out_element_q, out_element_d;
  logic                   out_last_q, out_last_d;

  status_e         st;
  logic            ins_en, del_en, rot_en, read_ok;
  logic [IdxW-1:0] idx;
  logic [CmpW-1:0] pos_x, cnt_x;
  logic            empty, full, slot_free, load;

  assign pos_x     = CmpW'(pos_q);
  assign cnt_x     = CmpW'(cnt_q);
  assign empty     = (cnt_q == '0);
  assign full      = (cnt_q == CntW'(CAPACITY));
  assign slot_free = !out_valid_q || out_ready_i;

  // decode status and cell operation of the held command
  always_comb begin
    st      = ST_OK;
    ins_en  = 1'b0;
    del_en  = 1'b0;
    read_ok = 1'b0;
    idx     = '0;
    unique case (op_e'(op_q))
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ins_en = 1'b1;
          idx    = (op_q == OP_INS_FRONT) ? '0 : IdxW'(cnt_q);
        end
      end
      OP_INS_AT: begin
        if (pos_q == '0) begin
          st = ST_INVALID;
        end else if (pos_x > cnt_x + CmpW'(1)) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          ins_en = 1'b1;
          idx    = IdxW'(pos_x - CmpW'(1));
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (empty) begin
          st = ST_UNDER;
        end else begin
          del_en = 1'b1;
          idx    = (op_q == OP_DEL_FRONT) ? '0 : IdxW'(cnt_q - CntW'(1));
        end
      end
      OP_DEL_AT: begin
        if (empty) begin
          st = ST_UNDER;
        end else if (pos_q == '0) begin
          st = ST_INVALID;
        end else if (pos_x > cnt_x) begin
          st = ST_RANGE;
        end else begin
          del_en = 1'b1;
          idx    = IdxW'(pos_x - CmpW'(1));
        end
      end
      OP_READ: begin
        if (empty) begin
          st = ST_UNDER;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: st = ST_INVALID;
    endcase
  end

  assign rot_en = cmd_i.read_step;

  // shift the cell row: open a gap, close a gap, or rotate by one toward the front
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
      if (cmd_i.exec && ins_en) begin
        if (IdxW'(i) == idx) begin
          cell_d[i] = val_q;
        end else if (IdxW'(i) > idx) begin
          cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end
      end else if ((cmd_i.exec && del_en) || rot_en) begin
        if (rot_en && (CntW'(i + 1) == cnt_q)) begin
          cell_d[i] = cell_q[0];
        end else if (rot_en || (IdxW'(i) >= idx)) begin
          cell_d[i] = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.exec && ins_en) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.exec && del_en) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_comb begin
    rd_d = rd_q;
    if (cmd_i.exec && read_ok) begin
      rd_d = cnt_q;
    end else if (cmd_i.read_step) begin
      rd_d = rd_q - CntW'(1);
    end
  end

  assign load = (cmd_i.exec && !read_ok) || cmd_i.read_step;

  always_comb begin
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_element_d = out_element_q;
    out_last_d    = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (cmd_i.read_step) begin
        out_status_d  = ST_OK;
        out_element_d = cell_q[0];
        out_last_d    = (rd_q == CntW'(1));
      end else begin
        out_status_d  = st;
        out_element_d = '0;
        out_last_d    = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      cell_q[i] <= cell_d[i];
    end
    out_status_q  <= out_status_d;
    out_element_q <= out_element_d;
    out_last_q    <= out_last_d;
  end

  assign sts_o.slot_free = slot_free;
  assign sts_o.read_go   = read_ok;
  assign sts_o.read_last = (rd_q == CntW'(1));

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_element_o = out_element_q;
  assign out_last_o    = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded result not presented");

  a_read_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.read_step |=> $stable(cnt_q))
    else $error("count changed during read out");

endmodule

@@ hw/rtl/positional_list_engine.sv @@
// Top level of the positional list engine: ordered list of signed 32-bit values.
// Instantiates ple_ctrl and ple_dp; uses ple_pkg.
//
// Input stream: one beat is one command. tuser carries the opcode, tdata the
// value to insert and the 1-based position. Output stream: tuser carries the
// status, tdata the element read out (zero otherwise), tlast marks the final
// beat of a command. Every command gives one beat, except a read out of a
// non-empty list, which gives one beat per held element from front to back.
// A command is taken in the idle state and executed once the output register
// has room; a new command is taken only after the last one has finished.
// Insert and delete shift the whole cell row when the command executes;
// read out rotates the row by one cell per beat and ends with it restored.
// The output register frees the input side: a new command is taken while a
// result still waits. When the receiver stalls, execution waits for the
// output register to drain and the input side stalls after one command.
// Reset empties the list and drops any pending output beat.
module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::CapacityDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [ple_pkg::InDataW-1:0]      s_axis_tdata_i,  // value[31:0], position[38:32]
  input  logic [ple_pkg::OpW-1:0]          s_axis_tuser_i,  // opcode[2:0]
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [ple_pkg::OutDataW-1:0]     m_axis_tdata_o,  // element[31:0]
  output logic [ple_pkg::StW-1:0]          m_axis_tuser_o,  // status[2:0]
  output logic                             m_axis_tlast_o
);
  import ple_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [ValW-1:0] element;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ple_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (s_axis_tuser_i),
    .value_i       (s_axis_tdata_i[ValW-1:0]),
    .position_i    (s_axis_tdata_i[ValW+PosW-1:ValW]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_status_o  (m_axis_tuser_o),
    .out_element_o (element),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutDataW'(element);

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench of positional_list_engine: directed table then random commands.
// Shadow list or typed row predicts each result beat, idle/stall patterns vary per phase.
// Depends on ple_pkg and the positional_list_engine RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int unsigned Capacity = CapacityDef;
  localparam logic [OpW-1:0] OpUnused = 3'd7;
  localparam int RandomPerPhase = 56;
  localparam int DirectedRows = 25;

  typedef struct {
    status_e            status;
    logic signed [31:0] element;
    logic               last;
  } beat_t;

  typedef struct {
    logic [OpW-1:0]  op;
    logic [ValW-1:0] value;
    logic [PosW-1:0] pos;
    int              reps;
    bit              typed;
    status_e         status;
  } cmd_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [OpW-1:0]      s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [StW-1:0]      m_axis_tuser_o;
  logic                m_axis_tlast_o;

  logic signed [31:0] held_values[$];
  beat_t              beats_due[$];
  int                 sender_idle_pct = 31;
  int                 receiver_stall_pct = 82;
  int                 n_mismatches = 0;
  int                 n_commands = 0;
  int                 n_beats = 0;
  int                 n_full_hits = 0;
  int                 n_reads = 0;

  cmd_row_t directed_rows [0:DirectedRows-1] = '{
    '{OP_DEL_FRONT, 32'h0000_0000, 7'd0,   1,  1'b1, ST_UNDER},
    '{OP_DEL_BACK,  32'h0000_0000, 7'd0,   1,  1'b1, ST_UNDER},
    '{OP_DEL_AT,    32'h0000_0000, 7'd0,   1,  1'b1, ST_UNDER},
    '{OP_DEL_AT,    32'h0000_0000, 7'd127, 1,  1'b1, ST_UNDER},
    '{OP_READ,      32'h0000_0000, 7'd0,   1,  1'b1, ST_UNDER},
    '{OP_INS_AT,    32'h1234_5678, 7'd0,   1,  1'b1, ST_INVALID},
    '{OP_INS_AT,    32'h1234_5678, 7'd2,   1,  1'b1, ST_RANGE},
    '{OpUnused,     32'h0000_0000, 7'd0,   1,  1'b1, ST_INVALID},
    '{OP_INS_AT,    32'h8000_0000, 7'd1,   1,  1'b1, ST_OK},
    '{OP_INS_FRONT, 32'h7FFF_FFFF, 7'd0,   1,  1'b1, ST_OK},
    '{OP_INS_BACK,  32'hFFFF_FFFF, 7'd0,   1,  1'b1, ST_OK},
    '{OP_INS_AT,    32'h5555_5555, 7'd4,   1,  1'b1, ST_OK},
    '{OP_INS_AT,    32'hAAAA_AAAA, 7'd2,   1,  1'b1, ST_OK},
    '{OP_READ,      32'h0000_0000, 7'd0,   1,  1'b0, ST_OK},
    '{OP_DEL_AT,    32'h0000_0000, 7'd0,   1,  1'b1, ST_INVALID},
    '{OP_DEL_AT,    32'h0000_0000, 7'd6,   1,  1'b1, ST_RANGE},
    '{OP_DEL_AT,    32'h0000_0000, 7'd3,   1,  1'b1, ST_OK},
    '{OP_INS_AT,    32'h0F0F_0F0F, 7'd127, 1,  1'b1, ST_RANGE},
    '{OP_INS_BACK,  32'h0000_0100, 7'd0,   14, 1'b0, ST_OK},
    '{OP_INS_AT,    32'h3333_3333, 7'd17,  1,  1'b1, ST_FULL},
    '{OP_INS_FRONT, 32'hCCCC_CCCC, 7'd0,   1,  1'b1, ST_FULL},
    '{OP_READ,      32'h0000_0000, 7'd0,   1,  1'b0, ST_OK},
    '{OP_DEL_AT,    32'h0000_0000, 7'd16,  1,  1'b1, ST_OK},
    '{OP_DEL_FRONT, 32'h0000_0000, 7'd0,   16, 1'b0, ST_OK},
    '{OpUnused,     32'hFFFF_FFFF, 7'd127, 1,  1'b1, ST_INVALID}
  };

  positional_list_engine i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic beat_t single_beat(status_e status);
    beat_t b;
    b.status  = status;
    b.element = '0;
    b.last    = 1'b1;
    return b;
  endfunction

  function automatic void predict_command(input logic [OpW-1:0] op,
                                          input logic signed [31:0] value,
                                          input logic [PosW-1:0] pos,
                                          output beat_t results[$]);
    int    n;
    beat_t b;
    n = held_values.size();
    results = {};
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (n >= Capacity) begin
          results.push_back(single_beat(ST_FULL));
        end else begin
          if (op == OP_INS_FRONT) held_values.push_front(value);
          else held_values.push_back(value);
          results.push_back(single_beat(ST_OK));
        end
      end
      OP_INS_AT: begin
        if (pos == 0) results.push_back(single_beat(ST_INVALID));
        else if (int'(pos) > n + 1) results.push_back(single_beat(ST_RANGE));
        else if (n >= Capacity) results.push_back(single_beat(ST_FULL));
        else begin
          held_values.insert(int'(pos) - 1, value);
          results.push_back(single_beat(ST_OK));
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (n == 0) begin
          results.push_back(single_beat(ST_UNDER));
        end else begin
          if (op == OP_DEL_FRONT) void'(held_values.pop_front());
          else void'(held_values.pop_back());
          results.push_back(single_beat(ST_OK));
        end
      end
      OP_DEL_AT: begin
        if (n == 0) results.push_back(single_beat(ST_UNDER));
        else if (pos == 0) results.push_back(single_beat(ST_INVALID));
        else if (int'(pos) > n) results.push_back(single_beat(ST_RANGE));
        else begin
          held_values.delete(int'(pos) - 1);
          results.push_back(single_beat(ST_OK));
        end
      end
      OP_READ: begin
        if (n == 0) begin
          results.push_back(single_beat(ST_UNDER));
        end else begin
          for (int i = 0; i < n; i++) begin
            b.status  = ST_OK;
            b.element = held_values[i];
            b.last    = (i == n - 1);
            results.push_back(b);
          end
        end
      end
      default: results.push_back(single_beat(ST_INVALID));
    endcase
    if (results[0].status == ST_FULL) n_full_hits++;
    if (op == OP_READ && n > 0) n_reads++;
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb_top: mismatch at %0t: %s", $realtime, what);
    n_mismatches++;
  endtask

  task automatic issue_command(input logic [OpW-1:0] op, input logic [ValW-1:0] value,
                               input logic [PosW-1:0] pos, input bit typed,
                               input status_e typed_status);
    beat_t fresh[$];
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, pos, value};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_command(op, value, pos, fresh);
    if (typed) beats_due.push_back(single_beat(typed_status));
    else foreach (fresh[i]) beats_due.push_back(fresh[i]);
    n_commands++;
  endtask

  task automatic issue_random_command();
    int              n;
    int              r;
    int              grow;
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    n    = held_values.size();
    r    = $urandom_range(0, 99);
    grow = (n < 10) ? 60 : 48;
    if (r < grow) op = OpW'($urandom_range(OP_INS_FRONT, OP_INS_AT));
    else if (r < 90) op = OpW'($urandom_range(OP_DEL_FRONT, OP_DEL_AT));
    else if (r < 98) op = OP_READ;
    else op = OpUnused;
    case ($urandom_range(0, 9))
      0:       pos = '0;
      1:       pos = PosW'($urandom_range(0, 127));
      default: pos = PosW'($urandom_range(1, n + 1));
    endcase
    issue_command(op, $urandom(), pos, 1'b0, ST_OK);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_beats++;
      if (beats_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status %0d element %h last %b",
                                  m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o));
      end else begin
        want = beats_due.pop_front();
        if (m_axis_tuser_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser_o, want.status));
        if (m_axis_tdata_o !== want.element)
          report_mismatch($sformatf("element %h, want %h", m_axis_tdata_o, want.element));
        if (m_axis_tlast_o !== want.last)
          report_mismatch($sformatf("last %b, want %b", m_axis_tlast_o, want.last));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        issue_command(directed_rows[r].op, directed_rows[r].value + k, directed_rows[r].pos,
                      directed_rows[r].typed, directed_rows[r].status);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 31;
          receiver_stall_pct = 82;
        end
        1: begin
          sender_idle_pct    = 82;
          receiver_stall_pct = 31;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase
      repeat (RandomPerPhase) issue_random_command();
    end

    s_axis_tvalid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("tb_top: %0d commands sent, %0d result beats checked, %0d mismatches",
             n_commands, n_beats, n_mismatches);
    $display("tb_top: %0d non-empty read outs, %0d inserts refused on a full list",
             n_reads, n_full_hits);
    if (n_mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_top: timeout with %0d beats still due", beats_due.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ple_pkg.sv
hw/rtl/ple_ctrl.sv
hw/rtl/ple_dp.sv
hw/rtl/positional_list_engine.sv
sim/tb_top.sv
